// ===== rtl/goq_pkg.sv =====
// shared types, widths and sector constants for the gradient orientation quantizer
package goq_pkg;

	localparam int DW   = 11;  // derivative width
	localparam int MAGW = 22;  // squared magnitude width, 2 * 1024^2 fits
	localparam int TANW = 19;  // q16 tangent constant width
	localparam int PRDW = 30;  // ax * tangent and ay << 16 compare width
	localparam int OW   = 3;   // orientation label width
	localparam int NTAN = 4;

	// tangents of 11.25, 33.75, 56.25 and 78.75 degrees in q16
	localparam logic [TANW-1:0] TAN_Q16 [NTAN] = '{
		19'd13036, 19'd43790, 19'd98082, 19'd329472
	};

	// chosen gradient handed to the sector stage
	typedef struct packed {
		logic [DW-1:0] ax;
		logic [DW-1:0] ay;
		logic          opp;     // dx and dy nonzero with opposite signs
		logic          border;
	} sector_in_t;

	function automatic logic [MAGW-1:0] sq_mag(input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] y);
		logic signed [MAGW-1:0] xs;
		logic signed [MAGW-1:0] ys;
		logic signed [MAGW-1:0] xx;
		logic signed [MAGW-1:0] yy;
		xs = {{(MAGW-DW){x[DW-1]}}, x};
		ys = {{(MAGW-DW){y[DW-1]}}, y};
		xx = xs * xs;
		yy = ys * ys;
		return unsigned'(xx) + unsigned'(yy);
	endfunction

	function automatic logic [DW-1:0] abs_val(input logic signed [DW-1:0] v);
		return v[DW-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

endpackage

// ===== rtl/gradient_orientation_quantizer.sv =====
// gradient orientation quantizer top level: three-stage pipeline, one pixel per clock
//
//  channel | valid     | ready     | payload
//  pixel   | pix_valid | pix_ready | dx_/dy_ blue, green, red, on_border
//  label   | ori_valid | ori_ready | orientation
//
// from accept to label valid: stages 1, 2, 3; one word per clock unless stalled
// stage 1 squares all six derivatives, stage 2 picks the channel and takes
// absolute values, stage 3 runs the four tangent compares into the output register
// each stage advances when the stage after it is empty or moving, so bubbles close up
// arst_n clears the stage valid bits only; payload registers are not reset
module gradient_orientation_quantizer
	import goq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  logic signed [DW-1:0] dx_blue,
	input  logic signed [DW-1:0] dy_blue,
	input  logic signed [DW-1:0] dx_green,
	input  logic signed [DW-1:0] dy_green,
	input  logic signed [DW-1:0] dx_red,
	input  logic signed [DW-1:0] dy_red,
	input  logic                 on_border,
	output logic                 ori_valid,
	input  logic                 ori_ready,
	output logic [OW-1:0]        orientation
);

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 en1, en2, en3;

	logic [MAGW-1:0]      mag_b_s1, mag_g_s1, mag_r_s1;
	logic signed [DW-1:0] dx_b_s1, dy_b_s1, dx_g_s1, dy_g_s1, dx_r_s1, dy_r_s1;
	logic                 border_s1;

	sector_in_t           sec_s2;
	sector_in_t           sec_d;
	logic [OW-1:0]        ori_d;
	logic [OW-1:0]        ori_s3;

	logic signed [DW-1:0] dx_sel, dy_sel;

	assign en3       = !valid_s3 || ori_ready;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign pix_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pix_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: squared magnitudes
	always_ff @(posedge clk) begin
		if (en1 && pix_valid) begin
			mag_b_s1  <= sq_mag(dx_blue, dy_blue);
			mag_g_s1  <= sq_mag(dx_green, dy_green);
			mag_r_s1  <= sq_mag(dx_red, dy_red);
			dx_b_s1   <= dx_blue;
			dy_b_s1   <= dy_blue;
			dx_g_s1   <= dx_green;
			dy_g_s1   <= dy_green;
			dx_r_s1   <= dx_red;
			dy_r_s1   <= dy_red;
			border_s1 <= on_border;
		end
	end

	// stage 2: strongest channel, ties to the lower channel
	always_comb begin
		priority if (mag_b_s1 >= mag_g_s1 && mag_b_s1 >= mag_r_s1) begin
			dx_sel = dx_b_s1;
			dy_sel = dy_b_s1;
		end else if (mag_g_s1 >= mag_r_s1) begin
			dx_sel = dx_g_s1;
			dy_sel = dy_g_s1;
		end else begin
			dx_sel = dx_r_s1;
			dy_sel = dy_r_s1;
		end
	end

	always_comb begin
		sec_d.ax     = abs_val(dx_sel);
		sec_d.ay     = abs_val(dy_sel);
		sec_d.opp    = (dx_sel != '0) && (dy_sel != '0) && (dx_sel[DW-1] != dy_sel[DW-1]);
		sec_d.border = border_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			sec_s2 <= sec_d;
		end
	end

	// stage 3: sector label into the output register
	goq_sector u_sector (
		.sec         (sec_s2),
		.orientation (ori_d)
	);

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			ori_s3 <= ori_d;
		end
	end

	assign ori_valid   = valid_s3;
	assign orientation = ori_s3;

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en3 && sec_s2.border |=> ori_valid && orientation == '0)
		else $error("border pixel gave a nonzero label");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en3 && sec_s2.ax == '0 && sec_s2.ay == '0 |=> orientation == '0)
		else $error("zero gradient gave a nonzero label");

	a_vertical: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en3 && !sec_s2.border && sec_s2.ax == '0 && sec_s2.ay != '0
		|=> orientation == OW'(4))
		else $error("vertical gradient not labeled four");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready == (!valid_s1 || !valid_s2 || !valid_s3 || ori_ready))
		else $error("input ready does not match pipeline occupancy");

	a_opp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && sec_d.opp |-> sec_d.ax != '0 && sec_d.ay != '0)
		else $error("opposite-sign flag set with a zero component");

endmodule

// ===== rtl/goq_sector.sv =====
// sector test against q16 tangents and folding into the 0..7 label
module goq_sector
	import goq_pkg::*;
(
	input  sector_in_t     sec,
	output logic [OW-1:0]  orientation
);

	logic [PRDW-1:0] ay_shift;
	logic [NTAN-1:0] hit;
	logic [OW-1:0]   q;
	logic            zero;

	assign ay_shift = PRDW'({sec.ay, 16'b0});
	assign zero     = (sec.ax == '0) && (sec.ay == '0);

	always_comb begin
		for (int k = 0; k < NTAN; k++) begin
			hit[k] = ay_shift >= (PRDW'(sec.ax) * PRDW'(TAN_Q16[k]));
		end
	end

	assign q = OW'($countones(hit));

	always_comb begin
		priority if (sec.border || zero) begin
			orientation = '0;
		end else if (sec.opp) begin
			orientation = OW'(4'd8 - {1'b0, q});
		end else begin
			orientation = q;
		end
	end

endmodule

// ===== sim/gradient_orientation_quantizer_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the gradient orientation quantizer: directed rows, then random pixels
module gradient_orientation_quantizer_test;
	import goq_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 850;
	localparam int DRAIN_AT     = 425;
	localparam int NO_LABEL     = -1;

	// tangents of the in-quadrant sector edges, q16
	localparam longint SECTOR_EDGE_Q16 [4] = '{13036, 43790, 98082, 329472};

	typedef struct packed {
		logic signed [DW-1:0] dxb;
		logic signed [DW-1:0] dyb;
		logic signed [DW-1:0] dxg;
		logic signed [DW-1:0] dyg;
		logic signed [DW-1:0] dxr;
		logic signed [DW-1:0] dyr;
		logic                 border;
	} pixel_t;

	typedef struct {
		pixel_t pix;
		int     label;  // NO_LABEL where the predictor decides
	} pixel_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 pix_valid;
	logic                 pix_ready;
	logic signed [DW-1:0] dx_blue;
	logic signed [DW-1:0] dy_blue;
	logic signed [DW-1:0] dx_green;
	logic signed [DW-1:0] dy_green;
	logic signed [DW-1:0] dx_red;
	logic signed [DW-1:0] dy_red;
	logic                 on_border;
	logic                 ori_valid;
	logic                 ori_ready;
	logic [OW-1:0]        orientation;

	// label typed into the table for the word on the bus, if any
	logic                 typed_known;
	logic [OW-1:0]        typed_label;

	pixel_t               applied_pixel;
	logic [OW-1:0]        expected_labels [$];
	pixel_row_t           directed_rows [$];
	int                   mismatches;
	int                   cycle_count;

	gradient_orientation_quantizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.dx_blue    (dx_blue),
		.dy_blue    (dy_blue),
		.dx_green   (dx_green),
		.dy_green   (dy_green),
		.dx_red     (dx_red),
		.dy_red     (dy_red),
		.on_border  (on_border),
		.ori_valid  (ori_valid),
		.ori_ready  (ori_ready),
		.orientation(orientation)
	);

	assign applied_pixel = {dx_blue, dy_blue, dx_green, dy_green, dx_red, dy_red, on_border};

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// strongest channel, then sector count against the q16 tangents
	function automatic logic [OW-1:0] predict_label(input pixel_t p);
		int     mag_b;
		int     mag_g;
		int     mag_r;
		int     dx;
		int     dy;
		longint ax;
		longint ay;
		int     sector;
		mag_b = int'(p.dxb) * int'(p.dxb) + int'(p.dyb) * int'(p.dyb);
		mag_g = int'(p.dxg) * int'(p.dxg) + int'(p.dyg) * int'(p.dyg);
		mag_r = int'(p.dxr) * int'(p.dxr) + int'(p.dyr) * int'(p.dyr);
		if (p.border)
			return '0;
		if (mag_b >= mag_g && mag_b >= mag_r) begin
			dx = p.dxb;
			dy = p.dyb;
		end else if (mag_g >= mag_r) begin
			dx = p.dxg;
			dy = p.dyg;
		end else begin
			dx = p.dxr;
			dy = p.dyr;
		end
		if (dx == 0 && dy == 0)
			return '0;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sector = 0;
		foreach (SECTOR_EDGE_Q16[k])
			if ((ay << 16) >= ax * SECTOR_EDGE_Q16[k])
				sector++;
		// second and fourth quadrants mirror the sector index
		if ((dx < 0 && dy > 0) || (dx > 0 && dy < 0))
			return OW'(8 - sector);
		return OW'(sector);
	endfunction

	function automatic logic signed [DW-1:0] rand_span(input int lo, input int hi);
		int v;
		v = lo + int'($urandom_range(0, hi - lo));
		return DW'(v);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		int     kind;
		int     bnd;
		longint lim;
		longint ax;
		longint ay;
		int     a;
		int     b;
		int     s;
		kind = $urandom_range(0, 9);
		p.dxb = rand_span(-1024, 1023);
		p.dyb = rand_span(-1024, 1023);
		p.dxg = rand_span(-1024, 1023);
		p.dyg = rand_span(-1024, 1023);
		p.dxr = rand_span(-1024, 1023);
		p.dyr = rand_span(-1024, 1023);
		p.border = ($urandom_range(0, 15) == 0);
		case (kind)
			3, 4: begin
				p.dxb = rand_span(-1020, 1020);
				p.dyb = rand_span(-1020, 1020);
				p.dxg = rand_span(-1020, 1020);
				p.dyg = rand_span(-1020, 1020);
				p.dxr = rand_span(-1020, 1020);
				p.dyr = rand_span(-1020, 1020);
			end
			5, 6: begin
				// strong channel sitting right at a sector edge, weak others
				bnd = $urandom_range(0, 3);
				lim = (1022 * 65536) / SECTOR_EDGE_Q16[bnd];
				if (lim > 1023)
					lim = 1023;
				ax = $urandom_range(32, int'(lim));
				ay = ((ax * SECTOR_EDGE_Q16[bnd]) >> 16) + $urandom_range(0, 2) - 1;
				if (ay < 0)
					ay = 0;
				a = $urandom_range(0, 1) ? -int'(ax) : int'(ax);
				b = $urandom_range(0, 1) ? -int'(ay) : int'(ay);
				p.dxb = rand_span(-20, 20);
				p.dyb = rand_span(-20, 20);
				p.dxg = rand_span(-20, 20);
				p.dyg = rand_span(-20, 20);
				p.dxr = rand_span(-20, 20);
				p.dyr = rand_span(-20, 20);
				case ($urandom_range(0, 2))
					0: begin
						p.dxb = DW'(a);
						p.dyb = DW'(b);
					end
					1: begin
						p.dxg = DW'(a);
						p.dyg = DW'(b);
					end
					default: begin
						p.dxr = DW'(a);
						p.dyr = DW'(b);
					end
				endcase
			end
			7: begin
				// green gets blue's magnitude and red does for half of s, directions vary; blue or red may be weakened
				a = rand_span(-1020, 1020);
				b = rand_span(-1020, 1020);
				s = $urandom_range(0, 7);
				p.dxb = DW'(a);
				p.dyb = DW'(b);
				p.dxg = DW'(s[0] ? (s[1] ? -b : b) : (s[1] ? -a : a));
				p.dyg = DW'(s[0] ? (s[2] ? -a : a) : (s[2] ? -b : b));
				p.dxr = DW'(s[2] ? b : -a);
				p.dyr = DW'(s[1] ? -a : b);
				case ($urandom_range(0, 2))
					0: begin
						p.dxb = rand_span(-3, 3);
						p.dyb = rand_span(-3, 3);
					end
					1: begin
						p.dxr = rand_span(-3, 3);
						p.dyr = rand_span(-3, 3);
					end
					default: ;
				endcase
			end
			8: begin
				p.dxb = rand_span(-3, 3);
				p.dyb = rand_span(-3, 3);
				p.dxg = rand_span(-3, 3);
				p.dyg = rand_span(-3, 3);
				p.dxr = rand_span(-3, 3);
				p.dyr = rand_span(-3, 3);
			end
			9: p.border = 1'b1;
			default: ;
		endcase
		return p;
	endfunction

	task automatic add_row(input int xb, input int yb, input int xg, input int yg,
			input int xr, input int yr, input bit border, input int label);
		pixel_row_t r;
		r.pix = {DW'(xb), DW'(yb), DW'(xg), DW'(yg), DW'(xr), DW'(yr), border};
		r.label = label;
		directed_rows = {directed_rows, r};
	endtask

	// one pixel word: optional gap, then hold valid until taken
	task automatic send_pixel(input pixel_t p, input int label, input bit steady);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid   <= 1'b1;
		dx_blue     <= p.dxb;
		dy_blue     <= p.dyb;
		dx_green    <= p.dxg;
		dy_green    <= p.dyg;
		dx_red      <= p.dxr;
		dy_red      <= p.dyr;
		on_border   <= p.border;
		typed_known <= (label != NO_LABEL);
		typed_label <= OW'(label);
		do @(posedge clk); while (!pix_ready);
	endtask

	task automatic wait_labels_drained();
		pix_valid <= 1'b0;
		do @(posedge clk); while (expected_labels.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && pix_ready)
				expected_labels = {expected_labels,
					typed_known ? typed_label : predict_label(applied_pixel)};
			if (ori_valid && ori_ready) begin
				if (expected_labels.size() == 0)
					report_mismatch($sformatf("label word %0d with nothing pending",
						orientation));
				else if (orientation !== expected_labels[0])
					report_mismatch($sformatf("orientation %0d, expected %0d",
						orientation, expected_labels[0]));
				if (expected_labels.size() != 0)
					void'(expected_labels.pop_front());
			end
		end
	end

	initial begin : label_sink
		int stall;
		bit steady;
		ori_ready = 1'b0;
		steady = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				ori_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			ori_ready <= 1'b1;
			do @(posedge clk); while (!ori_valid);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** gradient_orientation_quantizer: FAILED **");
		$finish;
	end

	initial begin : pixel_source
		bit steady;
		arst_n      = 1'b0;
		pix_valid   = 1'b0;
		dx_blue     = '0;
		dy_blue     = '0;
		dx_green    = '0;
		dy_green    = '0;
		dx_red      = '0;
		dy_red      = '0;
		on_border   = 1'b0;
		typed_known = 1'b0;
		typed_label = '0;
		mismatches  = 0;
		steady      = 1'b0;

		// zero gradient, borders, axis and diagonal extremes
		add_row(0, 0, 0, 0, 0, 0, 0, 0);
		add_row(1023, 1023, 1023, 1023, 1023, 1023, 1, 0);
		add_row(-1024, -1024, -1024, -1024, -1024, -1024, 1, 0);
		add_row(-1024, -1024, -1024, -1024, -1024, -1024, 0, 2);
		add_row(1023, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 1023, 0, 0, 0, 0, 0, 4);
		add_row(-1024, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, -1024, 0, 0, 0, 0, 0, 4);
		add_row(1000, -1000, 0, 0, 0, 0, 0, 6);
		add_row(-1000, 1000, 0, 0, 0, 0, 0, 6);
		add_row(-1000, -1000, 0, 0, 0, 0, 0, 2);
		// magnitude ties resolve toward blue, then green
		add_row(300, 0, 0, 300, 0, 0, 0, 0);
		add_row(1, 1, 0, 300, 300, 0, 0, 4);
		add_row(10, 5, 0, 20, -700, 300, 0, NO_LABEL);
		add_row(10, 5, 0, 20, -700, 300, 1, 0);
		// one step either side of each sector edge
		add_row(1000, 198, 0, 0, 0, 0, 0, NO_LABEL);
		add_row(1000, 199, 0, 0, 0, 0, 0, NO_LABEL);
		add_row(0, 0, 1000, 668, 0, 0, 0, NO_LABEL);
		add_row(0, 0, 1000, 669, 0, 0, 0, NO_LABEL);
		add_row(0, 0, 0, 0, 600, 897, 0, NO_LABEL);
		add_row(0, 0, 0, 0, 600, 898, 0, NO_LABEL);
		add_row(200, 1005, 0, 0, 0, 0, 0, NO_LABEL);
		add_row(200, 1006, 0, 0, 0, 0, 0, NO_LABEL);
		add_row(-200, 1006, 0, 0, 0, 0, 0, NO_LABEL);
		add_row(3, -1, -2, 2, 1, -3, 0, NO_LABEL);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_pixel(directed_rows[i].pix, directed_rows[i].label, 1'b0);
		wait_labels_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			if (n == DRAIN_AT)
				wait_labels_drained();
			send_pixel(rand_pixel(), NO_LABEL, steady);
		end
		wait_labels_drained();
		repeat (8) @(posedge clk);

		if (expected_labels.size() != 0)
			report_mismatch($sformatf("%0d labels never arrived", expected_labels.size()));
		if (mismatches == 0)
			$display("** gradient_orientation_quantizer: PASSED **");
		else
			$display("** gradient_orientation_quantizer: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/goq_pkg.sv
rtl/goq_sector.sv
rtl/gradient_orientation_quantizer.sv
sim/gradient_orientation_quantizer_test.sv
